// ===== hw/rtl/pdrm_pkg.sv =====
// Package: shared types, codes and constants of the packet drop rule matcher.
`timescale 1ns / 1ps
`default_nettype none
package pdrm_pkg;

	localparam int COUNTER_BITS_DEF = 32;
	localparam int RATE_BITS        = 32;
	localparam int ID_BITS          = 64;
	localparam int CFG_DATA_BITS    = 64;
	localparam int CFG_INDEX_BITS   = 3;
	localparam int TYPE_BITS        = 3;
	localparam int TOTAL_BITS       = 32;
	localparam int NUM_COUNTED      = 4;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_ID   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_ID     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TYPE_MASK   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PORTAL_MASK = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DROP_RATE   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_START_TIME  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_DROP  = 3'd6;

	localparam logic [TYPE_BITS-1:0] MSG_PUT = 3'd1;
	localparam logic [TYPE_BITS-1:0] MSG_GET = 3'd2;
	localparam logic [7:0] PUT_GET_BITS = 8'h06;
	localparam logic [31:0] PORTAL_MAX = 32'd63;

	typedef struct packed {
		logic [63:0] source_id;
		logic [63:0] dest_id;
		logic [2:0]  msg_type;
		logic [31:0] portal_index;
		logic [31:0] now_seconds;
		logic [31:0] random_draw;
	} in_item_t;

	typedef struct packed {
		logic        drop;
		logic        matched;
		logic [31:0] match_total;
		logic [31:0] drop_total;
		logic [31:0] type_drop_total;
	} out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pdrm_in_if.sv =====
// Interface: packet header request channel.
`timescale 1ns / 1ps
`default_nettype none
interface pdrm_in_if;
	logic               valid;
	logic               ready;
	pdrm_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pdrm_out_if.sv =====
// Interface: drop decision result channel.
`timescale 1ns / 1ps
`default_nettype none
interface pdrm_out_if;
	logic                valid;
	logic                ready;
	pdrm_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/packet_drop_rule_matcher.sv =====
// Top level: single-rule packet drop matcher with bit-serial modulo units.
//
// Usage: packet headers arrive on in_chan, one decision per header leaves on out_chan.
// A request is taken when valid and ready are both high. The rule is set through
// cfg_we / cfg_index / cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce. Writes take effect at once.
// An unmatched header goes from idle to the done state, and from there its result
// moves into the output register. A matched header first runs a restoring remainder
// unit that shifts one dividend bit per cycle over max(COUNTER_BITS, 32) bits; the
// next header is taken only once the result has moved out and the block is idle.
// The remainders of the new match count and of the random draw by the drop rate
// come out of two such units stepping side by side.
// Stall: the result sits in an output register; the block takes the next header
// while it waits, and holds that header's result until the register frees.
// Reset: arst_n clears all counters, loads the rule with match-any ids, no masks,
// rate one, no start delay and first drop at match zero.
`timescale 1ns / 1ps
`default_nettype none
module packet_drop_rule_matcher #(
	parameter int COUNTER_BITS = pdrm_pkg::COUNTER_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [pdrm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire [pdrm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	pdrm_in_if.sink                             in_chan,
	pdrm_out_if.source                          out_chan
);

	localparam int RB        = pdrm_pkg::RATE_BITS;
	localparam int NSTEPS    = (COUNTER_BITS > RB) ? COUNTER_BITS : RB;
	localparam int STEP_BITS = $clog2(NSTEPS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t state_q;

	logic [63:0]    rule_src_q;
	logic [63:0]    rule_dst_q;
	logic [7:0]     type_mask_q;
	logic [63:0]    portal_mask_q;
	logic [RB-1:0]  rate_q;
	logic [31:0]    start_time_q;

	logic                    start_pending_q;
	logic [COUNTER_BITS-1:0] match_cnt_q;
	logic [COUNTER_BITS-1:0] ndp_q;
	logic [COUNTER_BITS-1:0] drop_cnt_q;
	logic [COUNTER_BITS-1:0] type_cnt_q [pdrm_pkg::NUM_COUNTED];

	logic                    matched_q;
	pdrm_pkg::out_item_t     res_q;
	logic                    out_valid_q;
	pdrm_pkg::out_item_t     out_q;

	logic [NSTEPS-1:0]       dvd_cnt_q;
	logic [NSTEPS-1:0]       dvd_rnd_q;
	logic [RB-1:0]           rem_cnt_q;
	logic [RB-1:0]           rem_rnd_q;
	logic [STEP_BITS-1:0]    step_q;

	pdrm_pkg::in_item_t      hdr;
	logic                    accept;
	logic                    src_ok;
	logic                    dst_ok;
	logic [7:0]              tmask;
	logic                    type_ok;
	logic                    portal_ok;
	logic                    time_ok;
	logic                    match_w;
	logic                    drop_w;
	logic                    counted_w;
	logic [COUNTER_BITS-1:0] cnt_inc;
	logic [COUNTER_BITS-1:0] drop_inc;
	logic [COUNTER_BITS-1:0] type_cur;
	logic [COUNTER_BITS-1:0] type_inc;
	logic [RB-1:0]           rate_eff;
	logic [RB:0]             try_cnt;
	logic [RB:0]             try_rnd;
	logic [RB-1:0]           rem_cnt_nx;
	logic [RB-1:0]           rem_rnd_nx;
	logic                    out_free;

	function automatic logic id_match(input logic [63:0] want, input logic [63:0] have);
		logic hit;
		hit = (want == have) || (&want) ||
			((want[63:32] == have[63:32]) && (&want[31:0]));
		return hit;
	endfunction

	function automatic logic [pdrm_pkg::TOTAL_BITS-1:0] TOTAL_W(
		input logic [COUNTER_BITS-1:0] v);
		return pdrm_pkg::TOTAL_BITS'(v);
	endfunction

	assign hdr      = in_chan.payload;
	assign accept   = in_chan.valid && in_chan.ready;
	assign rate_eff = (rate_q == '0) ? RB'(1) : rate_q;
	assign out_free = !out_valid_q || out_chan.ready;

	always_comb begin
		src_ok    = id_match(rule_src_q, hdr.source_id);
		dst_ok    = id_match(rule_dst_q, hdr.dest_id);
		tmask     = (portal_mask_q != '0) ? (type_mask_q & pdrm_pkg::PUT_GET_BITS)
			: type_mask_q;
		type_ok   = (tmask == '0) || tmask[hdr.msg_type];
		portal_ok = (portal_mask_q == '0) ||
			(((hdr.msg_type == pdrm_pkg::MSG_PUT) || (hdr.msg_type == pdrm_pkg::MSG_GET)) &&
			(hdr.portal_index <= pdrm_pkg::PORTAL_MAX) &&
			portal_mask_q[hdr.portal_index[5:0]]);
		time_ok   = !(start_pending_q && (start_time_q > hdr.now_seconds));
		match_w   = time_ok && src_ok && dst_ok && type_ok && portal_ok;
		drop_w    = match_w && (match_cnt_q == ndp_q);
		counted_w = !hdr.msg_type[2];
		cnt_inc   = match_cnt_q + COUNTER_BITS'(1);
		drop_inc  = drop_cnt_q + COUNTER_BITS'(1);
		type_cur  = type_cnt_q[hdr.msg_type[1:0]];
		type_inc  = type_cur + COUNTER_BITS'(1);
	end

	always_comb begin
		try_cnt    = {rem_cnt_q, dvd_cnt_q[NSTEPS-1]};
		try_rnd    = {rem_rnd_q, dvd_rnd_q[NSTEPS-1]};
		rem_cnt_nx = (try_cnt >= {1'b0, rate_eff}) ? RB'(try_cnt - {1'b0, rate_eff})
			: try_cnt[RB-1:0];
		rem_rnd_nx = (try_rnd >= {1'b0, rate_eff}) ? RB'(try_rnd - {1'b0, rate_eff})
			: try_rnd[RB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			rule_src_q      <= '1;
			rule_dst_q      <= '1;
			type_mask_q     <= '0;
			portal_mask_q   <= '0;
			rate_q          <= RB'(1);
			start_time_q    <= '0;
			start_pending_q <= 1'b0;
			match_cnt_q     <= '0;
			ndp_q           <= '0;
			drop_cnt_q      <= '0;
			for (int i = 0; i < pdrm_pkg::NUM_COUNTED; i++) begin
				type_cnt_q[i] <= '0;
			end
			matched_q       <= 1'b0;
			out_valid_q     <= 1'b0;
			step_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pdrm_pkg::REG_SOURCE_ID:   rule_src_q    <= cfg_data;
					pdrm_pkg::REG_DEST_ID:     rule_dst_q    <= cfg_data;
					pdrm_pkg::REG_TYPE_MASK:   type_mask_q   <= cfg_data[7:0];
					pdrm_pkg::REG_PORTAL_MASK: portal_mask_q <= cfg_data;
					pdrm_pkg::REG_DROP_RATE:   rate_q        <= cfg_data[RB-1:0];
					pdrm_pkg::REG_START_TIME: begin
						start_time_q    <= cfg_data[31:0];
						start_pending_q <= (cfg_data[31:0] != '0);
					end
					pdrm_pkg::REG_FIRST_DROP:  ndp_q <= COUNTER_BITS'(cfg_data[31:0]);
					default: ;
				endcase
			end

			if (out_valid_q && out_chan.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						matched_q                 <= match_w;
						res_q.drop                <= drop_w;
						res_q.matched             <= match_w;
						res_q.match_total         <= match_w ? TOTAL_W(cnt_inc)
							: TOTAL_W(match_cnt_q);
						res_q.drop_total          <= drop_w ? TOTAL_W(drop_inc)
							: TOTAL_W(drop_cnt_q);
						res_q.type_drop_total     <= !counted_w ? '0
							: (drop_w ? TOTAL_W(type_inc) : TOTAL_W(type_cur));
						dvd_cnt_q                 <= NSTEPS'(cnt_inc);
						dvd_rnd_q                 <= NSTEPS'(hdr.random_draw);
						rem_cnt_q                 <= '0;
						rem_rnd_q                 <= '0;
						step_q                    <= STEP_BITS'(NSTEPS - 1);
						if (match_w) begin
							start_pending_q <= 1'b0;
							match_cnt_q     <= cnt_inc;
							state_q         <= S_RUN;
						end else begin
							state_q         <= S_DONE;
						end
						if (drop_w) begin
							drop_cnt_q <= drop_inc;
							if (counted_w) begin
								type_cnt_q[hdr.msg_type[1:0]] <= type_inc;
							end
						end
					end
				end
				S_RUN: begin
					rem_cnt_q <= rem_cnt_nx;
					rem_rnd_q <= rem_rnd_nx;
					dvd_cnt_q <= {dvd_cnt_q[NSTEPS-2:0], 1'b0};
					dvd_rnd_q <= {dvd_rnd_q[NSTEPS-2:0], 1'b0};
					if (step_q == '0) begin
						state_q <= S_DONE;
					end else begin
						step_q <= step_q - STEP_BITS'(1);
					end
				end
				S_DONE: begin
					if (matched_q && (rem_cnt_q == '0)) begin
						ndp_q <= match_cnt_q + COUNTER_BITS'(rem_rnd_q);
					end
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_chan.ready    = (state_q == S_IDLE);
	assign out_chan.valid   = out_valid_q;
	assign out_chan.payload = out_q;

	a_drop_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_chan.valid |-> (!out_chan.payload.drop || out_chan.payload.matched))
		else $error("drop reported on an unmatched packet");

	a_rem_below_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> ((rem_cnt_q < rate_eff) && (rem_rnd_q < rate_eff)))
		else $error("remainder not below drop rate");

	a_unmatched_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !match_w) |=> ((match_cnt_q == $past(match_cnt_q)) &&
			(drop_cnt_q == $past(drop_cnt_q)) && (state_q == S_DONE)))
		else $error("unmatched packet changed the counters");

	a_run_only_matched: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> matched_q)
		else $error("remainder unit running for an unmatched packet");

	a_result_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && !out_free) |=> ((state_q == S_DONE) && out_valid_q))
		else $error("pending result left before the output register freed");

endmodule
`default_nettype wire
